### rtl/core/cpc_pkg.sv
// Shared types and constants for the circle-versus-polygon collision block.
// Used by cpc_ctrl, cpc_datapath and circle_polygon_collision; no dependencies.
package cpc_pkg;

   // default table sizes
   localparam int MAX_POLYGONS_DEF = 128;
   localparam int MAX_VERTICES_DEF = 16;

   // field widths
   localparam int COORD_W  = 32;
   localparam int RADIUS_W = 25;

   // box minimum start value, 9999.0 in Q16.16
   localparam logic signed [COORD_W-1:0] BOX_MIN_START = 32'sd655294464;

   typedef enum logic [1:0] {
      ACT_VERTEX = 2'd0,
      ACT_CLOSE  = 2'd1,
      ACT_CLEAR  = 2'd2,
      ACT_QUERY  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STAT_OK          = 2'd0,
      STAT_VERTEX_DROP = 2'd1,
      STAT_POLY_DROP   = 2'd2
   } status_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load_vertex;
      logic close_poly;
      logic clear_table;
      logic query_start;
      logic meta_rd;
      logic poly_next;
      logic edge_reset;
      logic edge_issue;
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic       poly_done;
      logic       poly_pass;
      logic       edge_last;
      logic       pipe_busy;
      logic       hit;
      status_type load_status;
   } stat_type;

endpackage

### rtl/core/circle_polygon_collision.sv
// Top level of the circle-versus-polygon collision block.
// Depends on cpc_pkg, cpc_ctrl and cpc_datapath.
//
// An item is taken when start is high and busy is low. For append, close and
// clear, the result strobe rsp_valid rises on the cycle after the item is
// taken. A query walks the closed polygons: a META and a CHECK state per
// polygon for its bounding-box test, then one edge per cycle in the EDGE state
// for each polygon that passes, then the DRAIN state while the edge pipeline
// empties; the walk is set by the vertex memory giving one edge (two vertex
// reads) per cycle. Each result is on the rsp_ ports for exactly one cycle
// and cannot be held off. The radius register is written through csr_valid,
// always ready, and must only be written while the block is idle.
module circle_polygon_collision #(
   parameter int MAX_POLYGONS = cpc_pkg::MAX_POLYGONS_DEF,
   parameter int MAX_VERTICES = cpc_pkg::MAX_VERTICES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic [1:0]                    req_action,
   input  logic [cpc_pkg::COORD_W-1:0]   req_x_coord,
   input  logic [cpc_pkg::COORD_W-1:0]   req_y_coord,
   output logic                          rsp_valid,
   output logic                          rsp_collision,
   output logic [1:0]                    rsp_status,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [cpc_pkg::RADIUS_W-1:0]  csr_wdata
);
   import cpc_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   // radius register takes writes at any time
   assign csr_ready = 1'b1;

   cpc_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .req_action    (req_action),
      .busy          (busy),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_valid     (rsp_valid),
      .rsp_collision (rsp_collision),
      .rsp_status    (rsp_status)
   );

   cpc_datapath #(
      .MAX_POLYGONS (MAX_POLYGONS),
      .MAX_VERTICES (MAX_VERTICES)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .req_action  (req_action),
      .req_x_coord (req_x_coord),
      .req_y_coord (req_y_coord),
      .csr_valid   (csr_valid),
      .csr_wdata   (csr_wdata)
   );

endmodule

### rtl/core/cpc_ctrl.sv
// Sequencer for the collision block: takes items, steps the query walk.
// Depends on cpc_pkg; drives cpc_datapath through cmd_type / stat_type.
module cpc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [1:0]         req_action,
   output logic               busy,
   output cpc_pkg::cmd_type   cmd,
   input  cpc_pkg::stat_type  stat,
   output logic               rsp_valid,
   output logic               rsp_collision,
   output logic [1:0]         rsp_status
);
   import cpc_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_META,
      ST_CHECK,
      ST_EDGE,
      ST_DRAIN
   } state_type;

   state_type  state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_coll_ff, rsp_coll_in;
   status_type rsp_status_ff, rsp_status_in;
   logic       accept;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // next state, commands and result
   always_comb begin
      state_in      = state_ff;
      cmd           = '0;
      rsp_valid_in  = 1'b0;
      rsp_coll_in   = 1'b0;
      rsp_status_in = STAT_OK;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (action_type'(req_action))
                  ACT_VERTEX: begin
                     cmd.load_vertex = 1'b1;
                     rsp_valid_in    = 1'b1;
                     rsp_status_in   = stat.load_status;
                  end
                  ACT_CLOSE: begin
                     cmd.close_poly = 1'b1;
                     rsp_valid_in   = 1'b1;
                     rsp_status_in  = stat.load_status;
                  end
                  ACT_CLEAR: begin
                     cmd.clear_table = 1'b1;
                     rsp_valid_in    = 1'b1;
                  end
                  ACT_QUERY: begin
                     cmd.query_start = 1'b1;
                     state_in        = ST_META;
                  end
               endcase
            end
         end
         ST_META: begin
            if (stat.poly_done) begin
               state_in = ST_DRAIN;
            end else begin
               cmd.meta_rd = 1'b1;
               state_in    = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.poly_pass) begin
               cmd.edge_reset = 1'b1;
               state_in       = ST_EDGE;
            end else begin
               cmd.poly_next = 1'b1;
               state_in      = ST_META;
            end
         end
         ST_EDGE: begin
            cmd.edge_issue = 1'b1;
            if (stat.edge_last) begin
               cmd.poly_next = 1'b1;
               state_in      = ST_META;
            end
         end
         ST_DRAIN: begin
            if (!stat.pipe_busy) begin
               rsp_valid_in = 1'b1;
               rsp_coll_in  = stat.hit;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // hold state and the result strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         rsp_coll_ff   <= 1'b0;
         rsp_status_ff <= STAT_OK;
      end else begin
         state_ff      <= state_in;
         rsp_valid_ff  <= rsp_valid_in;
         rsp_coll_ff   <= rsp_coll_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_collision = rsp_coll_ff;
   assign rsp_status    = rsp_status_ff;

   // a result always leaves the block back in idle
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> state_ff == ST_IDLE)
      else $error("result strobe outside idle");

   // a table update answers on the next cycle
   a_load_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action != ACT_QUERY) |=> rsp_valid_ff)
      else $error("table update gave no result");

   // a query result carries ok status
   a_query_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && $past(state_ff == ST_DRAIN)) |-> rsp_status_ff == STAT_OK)
      else $error("query result with non-ok status");

endmodule

### rtl/core/cpc_datapath.sv
// Polygon table, bounding boxes and the exact edge-distance pipeline.
// Depends on cpc_pkg; commanded by cpc_ctrl.
module cpc_datapath #(
   parameter int MAX_POLYGONS = cpc_pkg::MAX_POLYGONS_DEF,
   parameter int MAX_VERTICES = cpc_pkg::MAX_VERTICES_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cpc_pkg::cmd_type              cmd,
   output cpc_pkg::stat_type             stat,
   input  logic [1:0]                    req_action,
   input  logic [cpc_pkg::COORD_W-1:0]   req_x_coord,
   input  logic [cpc_pkg::COORD_W-1:0]   req_y_coord,
   input  logic                          csr_valid,
   input  logic [cpc_pkg::RADIUS_W-1:0]  csr_wdata
);
   import cpc_pkg::*;

   localparam int PW     = (MAX_POLYGONS > 1) ? $clog2(MAX_POLYGONS) : 1;
   localparam int PCW    = $clog2(MAX_POLYGONS + 1);
   localparam int VW     = $clog2(MAX_VERTICES);
   localparam int VCW    = $clog2(MAX_VERTICES + 1);
   localparam int AW     = PW + VW;
   localparam int VDEPTH = 1 << AW;

   typedef struct packed {
      logic [VCW-1:0]             count;
      logic signed [COORD_W-1:0]  min_x;
      logic signed [COORD_W-1:0]  min_y;
      logic signed [COORD_W-1:0]  max_x;
      logic signed [COORD_W-1:0]  max_y;
   } meta_type;

   // tables
   logic [2*COORD_W-1:0] vmem [VDEPTH];
   meta_type             meta_mem [MAX_POLYGONS];

   // load state
   logic [PCW-1:0]            pcount_ff;
   logic [VCW-1:0]            open_ff;
   logic signed [COORD_W-1:0] bmin_x_ff, bmin_y_ff, bmax_x_ff, bmax_y_ff;
   logic signed [COORD_W-1:0] bmin_x_in, bmin_y_in, bmax_x_in, bmax_y_in;
   logic signed [COORD_W-1:0] cur_min_x, cur_min_y, cur_max_x, cur_max_y;
   logic signed [COORD_W-1:0] in_x, in_y;
   logic [RADIUS_W-1:0]       radius_ff;
   logic                      p_full, v_full, do_vertex, do_close;
   status_type                load_status;

   // query state
   logic signed [COORD_W-1:0] qx_ff, qy_ff;
   logic signed [33:0]        lo_x_ff, hi_x_ff, lo_y_ff, hi_y_ff;
   logic signed [33:0]        lo_x_in, hi_x_in, lo_y_in, hi_y_in;
   logic signed [33:0]        rad_e;
   logic [49:0]               r2_ff;
   logic [PCW-1:0]            qi_ff;
   logic [VW-1:0]             qj_ff, qk;
   meta_type                  mrd_ff;
   logic                      edge_last, pass;
   logic                      hit_ff;

   // edge pipeline
   logic [2*COORD_W-1:0] vj_ff, vk_ff;
   logic                 rv_ff, v1_ff, v2_ff, v3_ff, v4_ff, v5_ff;
   logic signed [32:0]   px_e, py_e, x1_e, y1_e, x2_e, y2_e;
   logic signed [32:0]   s1_a_ff, s1_b_ff, s1_c_ff, s1_d_ff, s1_ex_ff, s1_ey_ff;
   logic signed [65:0]   s2_ac_ff, s2_bd_ff, s2_cc_ff, s2_dd_ff, s2_aa_ff, s2_bb_ff;
   logic signed [65:0]   s2_xx_ff, s2_yy_ff, s2_ad_ff, s2_bc_ff;
   logic signed [67:0]   s3_len_ff, s3_dot_ff, s3_da_ff, s3_de_ff, cross_s;
   logic [67:0]          s3_cmag_ff;
   logic                 s4_near_ff, s4_far_ff, s4_hita_ff, s4_hite_ff, s4_big_ff;
   logic [63:0]          s4_c00_ff, s4_c01_ff, s4_c11_ff;
   logic [57:0]          s4_r00_ff, s4_r01_ff, s4_r10_ff, s4_r11_ff;
   logic                 s5_near_ff, s5_far_ff, s5_hita_ff, s5_hite_ff, s5_big_ff;
   logic [127:0]         s5_lhs_ff, s5_rhs_ff;
   logic                 edge_hit;

   // strict overlap of a query span with a box span
   function automatic logic span_pass(input logic signed [33:0] lo,
                                      input logic signed [33:0] hi,
                                      input logic signed [COORD_W-1:0] bmin,
                                      input logic signed [COORD_W-1:0] bmax);
      logic signed [33:0] mn, mx;
      mn = 34'(bmin);
      mx = 34'(bmax);
      return (lo < mx && mx < hi) || (lo < mn && mn < hi) || (mn < lo && hi < mx);
   endfunction

   // load decisions
   assign in_x      = req_x_coord;
   assign in_y      = req_y_coord;
   assign p_full    = (pcount_ff >= PCW'(MAX_POLYGONS));
   assign v_full    = (open_ff >= VCW'(MAX_VERTICES));
   assign do_vertex = cmd.load_vertex && !p_full && !v_full;
   assign do_close  = cmd.close_poly && !p_full && (open_ff != '0);

   always_comb begin
      priority case (1'b1)
         p_full && (req_action == ACT_VERTEX || req_action == ACT_CLOSE):
            load_status = STAT_POLY_DROP;
         v_full && req_action == ACT_VERTEX:
            load_status = STAT_VERTEX_DROP;
         default:
            load_status = STAT_OK;
      endcase
   end

   // restart the box on the first vertex, then widen it
   assign cur_max_x = (open_ff == '0) ? '0 : bmax_x_ff;
   assign cur_max_y = (open_ff == '0) ? '0 : bmax_y_ff;
   assign cur_min_x = (open_ff == '0) ? BOX_MIN_START : bmin_x_ff;
   assign cur_min_y = (open_ff == '0) ? BOX_MIN_START : bmin_y_ff;
   assign bmax_x_in = (in_x > cur_max_x) ? in_x : cur_max_x;
   assign bmax_y_in = (in_y > cur_max_y) ? in_y : cur_max_y;
   assign bmin_x_in = (in_x < cur_min_x) ? in_x : cur_min_x;
   assign bmin_y_in = (in_y < cur_min_y) ? in_y : cur_min_y;

   // query span around the centre
   assign rad_e   = 34'(radius_ff);
   assign lo_x_in = 34'(in_x) - rad_e;
   assign hi_x_in = 34'(in_x) + rad_e;
   assign lo_y_in = 34'(in_y) - rad_e;
   assign hi_y_in = 34'(in_y) + rad_e;

   // cursor status
   assign edge_last = (VCW'(qj_ff) == mrd_ff.count - 1'b1);
   assign qk        = edge_last ? '0 : qj_ff + 1'b1;
   assign pass      = span_pass(lo_x_ff, hi_x_ff, mrd_ff.min_x, mrd_ff.max_x) &&
                      span_pass(lo_y_ff, hi_y_ff, mrd_ff.min_y, mrd_ff.max_y);

   assign stat.load_status = load_status;
   assign stat.poly_done   = (qi_ff == pcount_ff);
   assign stat.poly_pass   = pass;
   assign stat.edge_last   = edge_last;
   assign stat.pipe_busy   = rv_ff | v1_ff | v2_ff | v3_ff | v4_ff | v5_ff;
   assign stat.hit         = hit_ff;

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pcount_ff <= '0;
         open_ff   <= '0;
         radius_ff <= '0;
         qi_ff     <= '0;
         qj_ff     <= '0;
         hit_ff    <= 1'b0;
         rv_ff     <= 1'b0;
         v1_ff     <= 1'b0;
         v2_ff     <= 1'b0;
         v3_ff     <= 1'b0;
         v4_ff     <= 1'b0;
         v5_ff     <= 1'b0;
      end else begin
         if (csr_valid) begin
            radius_ff <= csr_wdata;
         end
         if (do_vertex) begin
            open_ff <= open_ff + 1'b1;
         end
         if (cmd.close_poly) begin
            open_ff <= '0;
         end
         if (do_close) begin
            pcount_ff <= pcount_ff + 1'b1;
         end
         if (cmd.clear_table) begin
            pcount_ff <= '0;
            open_ff   <= '0;
         end
         // query cursor
         if (cmd.query_start) begin
            qi_ff <= '0;
         end else if (cmd.poly_next) begin
            qi_ff <= qi_ff + 1'b1;
         end
         if (cmd.edge_reset) begin
            qj_ff <= '0;
         end else if (cmd.edge_issue) begin
            qj_ff <= qj_ff + 1'b1;
         end
         // pipeline valids
         rv_ff <= cmd.edge_issue;
         v1_ff <= rv_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
         // accumulate hits
         if (cmd.query_start) begin
            hit_ff <= 1'b0;
         end else if (v5_ff && edge_hit) begin
            hit_ff <= 1'b1;
         end
      end
   end

   // open box and query operands
   always_ff @(posedge clock) begin
      if (do_vertex) begin
         bmin_x_ff <= bmin_x_in;
         bmin_y_ff <= bmin_y_in;
         bmax_x_ff <= bmax_x_in;
         bmax_y_ff <= bmax_y_in;
      end
      if (cmd.query_start) begin
         qx_ff   <= in_x;
         qy_ff   <= in_y;
         lo_x_ff <= lo_x_in;
         hi_x_ff <= hi_x_in;
         lo_y_ff <= lo_y_in;
         hi_y_ff <= hi_y_in;
         r2_ff   <= 50'(radius_ff) * 50'(radius_ff);
      end
   end

   // vertex memory: one write port, two read ports
   always_ff @(posedge clock) begin
      if (do_vertex) begin
         vmem[{pcount_ff[PW-1:0], open_ff[VW-1:0]}] <= {req_x_coord, req_y_coord};
      end
      if (cmd.edge_issue) begin
         vj_ff <= vmem[{qi_ff[PW-1:0], qj_ff}];
         vk_ff <= vmem[{qi_ff[PW-1:0], qk}];
      end
   end

   // polygon descriptor memory
   always_ff @(posedge clock) begin
      if (do_close) begin
         meta_mem[pcount_ff[PW-1:0]] <= '{count: open_ff, min_x: bmin_x_ff,
                                          min_y: bmin_y_ff, max_x: bmax_x_ff,
                                          max_y: bmax_y_ff};
      end
      if (cmd.meta_rd) begin
         mrd_ff <= meta_mem[qi_ff[PW-1:0]];
      end
   end

   // stage 1: differences
   assign px_e = {qx_ff[COORD_W-1], qx_ff};
   assign py_e = {qy_ff[COORD_W-1], qy_ff};
   assign x1_e = {vj_ff[2*COORD_W-1], vj_ff[2*COORD_W-1:COORD_W]};
   assign y1_e = {vj_ff[COORD_W-1], vj_ff[COORD_W-1:0]};
   assign x2_e = {vk_ff[2*COORD_W-1], vk_ff[2*COORD_W-1:COORD_W]};
   assign y2_e = {vk_ff[COORD_W-1], vk_ff[COORD_W-1:0]};

   always_ff @(posedge clock) begin
      s1_a_ff  <= px_e - x1_e;
      s1_b_ff  <= py_e - y1_e;
      s1_c_ff  <= x2_e - x1_e;
      s1_d_ff  <= y2_e - y1_e;
      s1_ex_ff <= px_e - x2_e;
      s1_ey_ff <= py_e - y2_e;
   end

   // stage 2: products
   always_ff @(posedge clock) begin
      s2_ac_ff <= 66'(s1_a_ff) * 66'(s1_c_ff);
      s2_bd_ff <= 66'(s1_b_ff) * 66'(s1_d_ff);
      s2_cc_ff <= 66'(s1_c_ff) * 66'(s1_c_ff);
      s2_dd_ff <= 66'(s1_d_ff) * 66'(s1_d_ff);
      s2_aa_ff <= 66'(s1_a_ff) * 66'(s1_a_ff);
      s2_bb_ff <= 66'(s1_b_ff) * 66'(s1_b_ff);
      s2_xx_ff <= 66'(s1_ex_ff) * 66'(s1_ex_ff);
      s2_yy_ff <= 66'(s1_ey_ff) * 66'(s1_ey_ff);
      s2_ad_ff <= 66'(s1_a_ff) * 66'(s1_d_ff);
      s2_bc_ff <= 66'(s1_b_ff) * 66'(s1_c_ff);
   end

   // stage 3: sums and cross magnitude
   assign cross_s = 68'(s2_ad_ff) - 68'(s2_bc_ff);

   always_ff @(posedge clock) begin
      s3_len_ff  <= 68'(s2_cc_ff) + 68'(s2_dd_ff);
      s3_dot_ff  <= 68'(s2_ac_ff) + 68'(s2_bd_ff);
      s3_da_ff   <= 68'(s2_aa_ff) + 68'(s2_bb_ff);
      s3_de_ff   <= 68'(s2_xx_ff) + 68'(s2_yy_ff);
      s3_cmag_ff <= cross_s[67] ? 68'(-cross_s) : 68'(cross_s);
   end

   // stage 4: region flags and partial products
   always_ff @(posedge clock) begin
      s4_near_ff <= (s3_len_ff == '0) || s3_dot_ff[67];
      s4_far_ff  <= (s3_dot_ff > s3_len_ff);
      s4_hita_ff <= ($unsigned(s3_da_ff) <= 68'(r2_ff));
      s4_hite_ff <= ($unsigned(s3_de_ff) <= 68'(r2_ff));
      s4_big_ff  <= |s3_cmag_ff[67:64];
      s4_c00_ff  <= 64'(s3_cmag_ff[31:0]) * 64'(s3_cmag_ff[31:0]);
      s4_c01_ff  <= 64'(s3_cmag_ff[31:0]) * 64'(s3_cmag_ff[63:32]);
      s4_c11_ff  <= 64'(s3_cmag_ff[63:32]) * 64'(s3_cmag_ff[63:32]);
      s4_r00_ff  <= 58'(r2_ff[24:0]) * 58'(s3_len_ff[32:0]);
      s4_r01_ff  <= 58'(r2_ff[24:0]) * 58'(s3_len_ff[65:33]);
      s4_r10_ff  <= 58'(r2_ff[49:25]) * 58'(s3_len_ff[32:0]);
      s4_r11_ff  <= 58'(r2_ff[49:25]) * 58'(s3_len_ff[65:33]);
   end

   // stage 5: assemble cross squared and radius squared times length
   always_ff @(posedge clock) begin
      s5_near_ff <= s4_near_ff;
      s5_far_ff  <= s4_far_ff;
      s5_hita_ff <= s4_hita_ff;
      s5_hite_ff <= s4_hite_ff;
      s5_big_ff  <= s4_big_ff;
      s5_lhs_ff  <= 128'(s4_c00_ff) + (128'(s4_c01_ff) << 33) + (128'(s4_c11_ff) << 64);
      s5_rhs_ff  <= 128'(s4_r00_ff) + (128'(s4_r01_ff) << 33) +
                    (128'(s4_r10_ff) << 25) + (128'(s4_r11_ff) << 58);
   end

   // pick the nearest point of the edge
   always_comb begin
      priority if (s5_near_ff) begin
         edge_hit = s5_hita_ff;
      end else if (s5_far_ff) begin
         edge_hit = s5_hite_ff;
      end else begin
         edge_hit = !s5_big_ff && (s5_lhs_ff <= s5_rhs_ff);
      end
   end

   // open polygon never outgrows its slot
   a_open_bound: assert property (@(posedge clock) disable iff (reset)
      open_ff <= VCW'(MAX_VERTICES))
      else $error("open vertex count beyond limit");

   // table never outgrows its slots
   a_poly_bound: assert property (@(posedge clock) disable iff (reset)
      pcount_ff <= PCW'(MAX_POLYGONS))
      else $error("polygon count beyond limit");

   // edges are walked only for a polygon that holds vertices
   a_edge_count: assert property (@(posedge clock) disable iff (reset)
      cmd.edge_issue |-> (mrd_ff.count != '0 && qi_ff < pcount_ff))
      else $error("edge walk on an empty or missing polygon");

endmodule

### bench/tb_circle_polygon_collision.sv
// Self-checking bench for circle_polygon_collision: polygon loads, table limits and queries.
// Depends on cpc_pkg and the RTL of circle_polygon_collision; the bench carries its own predictor.
module tb_circle_polygon_collision;
   import cpc_pkg::*;

   localparam int NPOLY     = 128;
   localparam int NVERT     = 16;
   localparam int SPAN      = 300 * 65536;   // most coordinates stay within +-300.0
   localparam int WD_LIMIT  = 60000;
   localparam int RADIUS_HI = 16777216;

   typedef enum logic [1:0] {
      K_ITEM,
      K_CSR,
      K_DRAIN,
      K_PHASE
   } entry_kind;

   typedef struct {
      entry_kind  kind;
      action_type act;
      logic [31:0] x;
      logic [31:0] y;
      int          val;
   } pending_entry;

   typedef struct {
      logic       collision;
      status_type status;
   } result_item;

   logic clock = 0;
   logic reset = 1;
   logic start = 0;
   logic busy;
   logic [1:0] req_action = '0;
   logic [COORD_W-1:0] req_x_coord = '0;
   logic [COORD_W-1:0] req_y_coord = '0;
   logic rsp_valid;
   logic rsp_collision;
   logic [1:0] rsp_status;
   logic csr_valid = 0;
   logic csr_ready;
   logic [RADIUS_W-1:0] csr_wdata = '0;

   pending_entry pending[$];
   result_item   expected_results[$];

   // predictor state
   int          poly_x[NPOLY*NVERT];
   int          poly_y[NPOLY*NVERT];
   int          poly_len[NPOLY];
   longint      bmin_x[NPOLY], bmin_y[NPOLY], bmax_x[NPOLY], bmax_y[NPOLY];
   int          poly_total;
   int          open_count;
   longint      radius;

   bit item_taken, csr_taken;
   int idle_pct;
   int errors, n_items, n_queries, n_hits, n_drops, idle_cycles;

   circle_polygon_collision DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_action(req_action), .req_x_coord(req_x_coord), .req_y_coord(req_y_coord),
      .rsp_valid(rsp_valid), .rsp_collision(rsp_collision), .rsp_status(rsp_status),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // exact squared distance of a point to one edge against the squared radius
   function automatic logic edge_touch(longint px, longint py, longint x1, longint y1,
                                       longint x2, longint y2, longint r2);
      logic signed [127:0] a, b, c, d, len, dot, cr, ex, ey, r2s;
      logic [127:0] lhs, rhs;
      a = px - x1; b = py - y1; c = x2 - x1; d = y2 - y1;
      r2s = r2;
      len = c * c + d * d;
      dot = a * c + b * d;
      if (len == 0 || dot < 0)
         return (a * a + b * b) <= r2s;
      if (dot > len) begin
         ex = px - x2; ey = py - y2;
         return (ex * ex + ey * ey) <= r2s;
      end
      cr = a * d - b * c;
      if (cr < 0)
         cr = -cr;
      // a cross product beyond 64 bits never counts as a touch
      if (cr[127:64] != 0)
         return 1'b0;
      lhs = cr[63:0] * cr[63:0];
      rhs = 128'(r2) * 128'(len);
      return lhs <= rhs;
   endfunction

   function automatic logic span_overlap(longint lo, longint hi, longint bmn, longint bmx);
      return (lo < bmx && bmx < hi) || (lo < bmn && bmn < hi) || (bmn < lo && hi < bmx);
   endfunction

   function automatic logic circle_hits(longint px, longint py);
      int n, k;
      longint r2;
      r2 = radius * radius;
      for (int i = 0; i < poly_total; i++) begin
         n = poly_len[i];
         if (!span_overlap(px - radius, px + radius, bmin_x[i], bmax_x[i])) continue;
         if (!span_overlap(py - radius, py + radius, bmin_y[i], bmax_y[i])) continue;
         for (int j = 0; j < n; j++) begin
            k = (j + 1 == n) ? 0 : j + 1;
            if (edge_touch(px, py, poly_x[i*NVERT+j], poly_y[i*NVERT+j],
                           poly_x[i*NVERT+k], poly_y[i*NVERT+k], r2))
               return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // advance the predictor by one accepted item
   function automatic result_item apply_item(action_type act, int x, int y);
      result_item res;
      int p;
      res.collision = 1'b0;
      res.status = STAT_OK;
      p = poly_total;
      case (act)
         ACT_VERTEX: begin
            if (p >= NPOLY) res.status = STAT_POLY_DROP;
            else if (open_count >= NVERT) res.status = STAT_VERTEX_DROP;
            else begin
               if (open_count == 0) begin
                  bmax_x[p] = 0; bmax_y[p] = 0;
                  bmin_x[p] = BOX_MIN_START; bmin_y[p] = BOX_MIN_START;
               end
               poly_x[p*NVERT+open_count] = x;
               poly_y[p*NVERT+open_count] = y;
               if (x > bmax_x[p]) bmax_x[p] = x;
               if (y > bmax_y[p]) bmax_y[p] = y;
               if (x < bmin_x[p]) bmin_x[p] = x;
               if (y < bmin_y[p]) bmin_y[p] = y;
               open_count++;
            end
         end
         ACT_CLOSE: begin
            if (p >= NPOLY) begin
               res.status = STAT_POLY_DROP;
               open_count = 0;
            end else if (open_count != 0) begin
               poly_len[p] = open_count;
               poly_total = p + 1;
               open_count = 0;
            end
         end
         ACT_CLEAR: begin
            poly_total = 0;
            open_count = 0;
         end
         default: res.collision = circle_hits(x, y);
      endcase
      return res;
   endfunction

   // stimulus helpers
   function automatic void add_item(action_type act, int x, int y);
      pending_entry e;
      e.kind = K_ITEM; e.act = act; e.x = x; e.y = y; e.val = 0;
      pending.push_back(e);
   endfunction

   function automatic void add_ctrl(entry_kind kind, int val);
      pending_entry e;
      e.kind = kind; e.act = ACT_VERTEX; e.x = '0; e.y = '0; e.val = val;
      pending.push_back(e);
   endfunction

   function automatic int pick_coord();
      if ($urandom_range(9) == 0)
         return int'($urandom());
      return int'($urandom_range(2 * SPAN)) - SPAN;
   endfunction

   // driver: change inputs at the falling edge, one update per signal per step
   always @(negedge clock) begin
      logic nxt_start, nxt_csr;
      pending_entry head;
      if (!reset) begin
         nxt_start = start;
         nxt_csr = csr_valid;
         if (item_taken) nxt_start = 1'b0;
         if (csr_taken) nxt_csr = 1'b0;
         item_taken = 1'b0;
         csr_taken = 1'b0;
         while (!nxt_start && !nxt_csr && pending.size() > 0 &&
                pending[0].kind == K_PHASE) begin
            idle_pct = pending[0].val;
            void'(pending.pop_front());
         end
         if (!nxt_start && !nxt_csr && pending.size() > 0) begin
            head = pending[0];
            case (head.kind)
               K_ITEM: begin
                  if (int'($urandom_range(99)) >= idle_pct) begin
                     req_action <= head.act;
                     req_x_coord <= head.x;
                     req_y_coord <= head.y;
                     nxt_start = 1'b1;
                     void'(pending.pop_front());
                  end
               end
               K_CSR: begin
                  // write the radius only while nothing is in flight
                  if (expected_results.size() == 0 && !busy) begin
                     csr_wdata <= RADIUS_W'(head.val);
                     nxt_csr = 1'b1;
                     void'(pending.pop_front());
                  end
               end
               default: begin
                  if (expected_results.size() == 0) void'(pending.pop_front());
               end
            endcase
         end
         start <= nxt_start;
         csr_valid <= nxt_csr;
      end
   end

   // monitor: sample at the rising edge, predict, check and watch for a hang
   always @(posedge clock) begin
      result_item exp_res, got;
      bit moved;
      if (!reset) begin
         moved = 1'b0;
         if (rsp_valid) begin
            moved = 1'b1;
            got.collision = rsp_collision;
            got.status = status_type'(rsp_status);
            if (expected_results.size() == 0) begin
               $display("%0t: result with none expected: collision %0b status %0d",
                        $time, got.collision, got.status);
               errors++;
            end else begin
               exp_res = expected_results.pop_front();
               if (got.collision !== exp_res.collision) begin
                  $display("%0t: collision mismatch: expected %0b actual %0b",
                           $time, exp_res.collision, got.collision);
                  errors++;
               end
               if (got.status !== exp_res.status) begin
                  $display("%0t: status mismatch: expected %0d actual %0d",
                           $time, exp_res.status, got.status);
                  errors++;
               end
            end
         end
         if (start && !busy) begin
            moved = 1'b1;
            item_taken = 1'b1;
            n_items++;
            exp_res = apply_item(action_type'(req_action), int'(req_x_coord),
                                 int'(req_y_coord));
            if (action_type'(req_action) == ACT_QUERY) begin
               n_queries++;
               if (exp_res.collision) n_hits++;
            end
            if (exp_res.status != STAT_OK) n_drops++;
            expected_results.push_back(exp_res);
         end
         if (csr_valid && csr_ready) begin
            moved = 1'b1;
            csr_taken = 1'b1;
            radius = csr_wdata;
         end
         if (moved) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WD_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, WD_LIMIT);
            $display("FAIL");
            $finish;
         end
      end
   end

   // stimulus and end of run
   initial begin
      int n, bx, by, cnt;
      idle_pct = 0;
      poly_total = 0; open_count = 0; radius = 0;
      errors = 0; n_items = 0; n_queries = 0; n_hits = 0; n_drops = 0; idle_cycles = 0;

      // directed: extremes, empty close, single vertex, zero-length edge, full polygon
      add_item(ACT_QUERY, 0, 0);
      add_item(ACT_CLOSE, 0, 0);
      add_item(ACT_VERTEX, 32'h8000_0000, 32'h7FFF_FFFF);
      add_item(ACT_VERTEX, 32'h7FFF_FFFF, 32'h8000_0000);
      add_item(ACT_CLOSE, 0, 0);
      add_item(ACT_QUERY, 32'hFFFF_FFFF, 32'h0000_0000);
      add_ctrl(K_CSR, RADIUS_HI);
      add_item(ACT_QUERY, 0, 0);
      add_item(ACT_VERTEX, 10 << 16, 10 << 16);
      add_item(ACT_CLOSE, 0, 0);
      add_item(ACT_QUERY, 12 << 16, 12 << 16);
      add_item(ACT_VERTEX, -20 << 16, 5 << 16);
      add_item(ACT_VERTEX, -20 << 16, 5 << 16);
      add_item(ACT_VERTEX, 20 << 16, -5 << 16);
      add_item(ACT_QUERY, -20 << 16, 5 << 16);
      add_item(ACT_CLOSE, 0, 0);
      add_item(ACT_QUERY, -25 << 16, 0);
      add_item(ACT_CLEAR, 0, 0);
      add_item(ACT_QUERY, 10 << 16, 10 << 16);
      for (int i = 0; i < NVERT + 2; i++)
         add_item(ACT_VERTEX, (i * 7) << 16, (i % 3) << 16);
      add_item(ACT_CLOSE, 0, 0);
      add_item(ACT_QUERY, 50 << 16, 1 << 16);

      // random: mostly well-formed polygons followed by queries
      for (int ph = 0; ph < 4; ph++) begin
         add_ctrl(K_DRAIN, 0);
         case (ph)
            0: add_ctrl(K_CSR, 0);
            1: add_ctrl(K_CSR, $urandom_range(RADIUS_HI));
            2: add_ctrl(K_CSR, RADIUS_HI);
            default: add_ctrl(K_CSR, $urandom_range(40 << 16));
         endcase
         add_ctrl(K_PHASE, (ph == 1) ? 73 : (ph == 2) ? 16 : 0);
         cnt = 0;
         while (cnt < 4) begin
            case ($urandom_range(9))
               0: begin add_item(ACT_CLEAR, 0, 0); cnt++; end
               1: begin add_item(action_type'($urandom_range(3)), $urandom(), $urandom()); cnt++; end
               default: begin
                  n = ($urandom_range(7) == 0) ? $urandom_range(NVERT + 2, NVERT - 1)
                                               : $urandom_range(5, 1);
                  bx = pick_coord(); by = pick_coord();
                  for (int j = 0; j < n; j++)
                     add_item(ACT_VERTEX, bx + int'($urandom_range(SPAN / 8)) - SPAN / 16,
                              by + int'($urandom_range(SPAN / 8)) - SPAN / 16);
                  if ($urandom_range(5) != 0) add_item(ACT_CLOSE, 0, 0);
                  for (int j = $urandom_range(3, 1); j > 0; j--) begin
                     add_item(ACT_QUERY, bx + int'($urandom_range(SPAN / 4)) - SPAN / 8,
                              by + int'($urandom_range(SPAN / 4)) - SPAN / 8);
                     cnt++;
                  end
                  cnt += n + 1;
               end
            endcase
         end
      end

      // fill every slot, then hit the full table with appends and closes
      add_ctrl(K_DRAIN, 0);
      add_ctrl(K_PHASE, 0);
      add_ctrl(K_CSR, 8 << 16);
      add_item(ACT_CLEAR, 0, 0);
      for (int i = 0; i < NPOLY; i++) begin
         if (i == NPOLY / 2) add_ctrl(K_PHASE, 73);
         add_item(ACT_VERTEX, ((i % 16) * 20) << 16, ((i / 16) * 20) << 16);
         add_item(ACT_CLOSE, 0, 0);
      end
      add_item(ACT_VERTEX, 1 << 16, 1 << 16);
      add_item(ACT_CLOSE, 0, 0);
      add_item(ACT_QUERY, 300 << 16, 140 << 16);
      add_item(ACT_QUERY, 305 << 16, 145 << 16);
      add_item(ACT_CLEAR, 0, 0);
      add_item(ACT_QUERY, 0, 0);

      repeat (10) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      wait (pending.size() == 0 && !start && !csr_valid);
      wait (expected_results.size() == 0);
      repeat (30) @(posedge clock);
      $display("Covered %0d items: %0d queries (%0d hits), %0d dropped loads.",
               n_items, n_queries, n_hits, n_drops);
      $display("Radius settings from zero to 256.0; %0d mismatches.", errors);
      if (errors == 0 && expected_results.size() == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
